@@ rtl/point_line_distance_filter_macros.svh @@
// ============================================================================
// Point-line distance filter assertion macros
// Shared concurrent assertion forms for the filter checker.
// ============================================================================
`ifndef POINT_LINE_DISTANCE_FILTER_MACROS_SVH
`define POINT_LINE_DISTANCE_FILTER_MACROS_SVH

// Antecedent implies consequent in the same cycle, off during reset
`define PLF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold outside reset
`define PLF_ASSERT_NEVER(lbl, clk, rstn, bad, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(bad)) \
        else $error(msg);

`endif

@@ rtl/plf_pkg.sv @@
// ============================================================================
// Point-line distance filter package
// Default widths, register map and width helpers shared by the filter.
// ============================================================================
`timescale 1ns / 1ps

package plf_pkg;

    // Default field widths
    localparam int COORD_BITS_DEF    = 16;
    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int INDEX_BITS_DEF    = 20;

    // Three spatial axes
    localparam int AXES = 3;

    // Cycles from an accepted point to its result strobe
    localparam int PIPE_LATENCY = 7;

    // Configuration register map
    localparam int CFG_ADDR_BITS = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_ANCHOR_X = 3'd0,
        REG_ANCHOR_Y = 3'd1,
        REG_ANCHOR_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MAX_DIST = 3'd6
    } cfg_reg_t;

    // Width left after an arithmetic right shift (at least the sign bit)
    function automatic int shr_width(input int w, input int s);
        return (w > s) ? (w - s) : 1;
    endfunction

    function automatic int max_width(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/plf_cfg_regs.sv @@
// ============================================================================
// Point-line distance filter configuration registers
// Holds line anchor, direction and threshold; keeps the squared threshold.
// ============================================================================
`timescale 1ns / 1ps

module plf_cfg_regs
    import plf_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [CFG_ADDR_BITS-1:0]       wr_addr,
    input  logic [COORD_BITS-1:0]          wr_data,
    output logic signed [COORD_BITS-1:0]   anchor_x,
    output logic signed [COORD_BITS-1:0]   anchor_y,
    output logic signed [COORD_BITS-1:0]   anchor_z,
    output logic signed [COORD_BITS-1:0]   dir_x,
    output logic signed [COORD_BITS-1:0]   dir_y,
    output logic signed [COORD_BITS-1:0]   dir_z,
    output logic [2*(COORD_BITS-1)-1:0]    lim_sq
);

    localparam int DIST_W = COORD_BITS - 1;
    localparam int LSQ_W  = 2 * DIST_W;

    // 1.0 in the direction format; vanishes if it does not fit the width
    localparam logic [COORD_BITS-1:0] DIR_ONE =
        {{(COORD_BITS-1){1'b0}}, 1'b1} << DIR_FRAC_BITS;

    logic [COORD_BITS-1:0] anchor_x_reg, anchor_y_reg, anchor_z_reg;
    logic [COORD_BITS-1:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [DIST_W-1:0]     max_dist_reg;
    logic [LSQ_W-1:0]      lim_sq_reg;

    // Register writes; unknown index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            anchor_z_reg <= '0;
            dir_x_reg    <= DIR_ONE;
            dir_y_reg    <= '0;
            dir_z_reg    <= '0;
            max_dist_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_addr))
                REG_ANCHOR_X: anchor_x_reg <= wr_data;
                REG_ANCHOR_Y: anchor_y_reg <= wr_data;
                REG_ANCHOR_Z: anchor_z_reg <= wr_data;
                REG_DIR_X:    dir_x_reg    <= wr_data;
                REG_DIR_Y:    dir_y_reg    <= wr_data;
                REG_DIR_Z:    dir_z_reg    <= wr_data;
                REG_MAX_DIST: max_dist_reg <= wr_data[DIST_W-1:0];
                default:      ;
            endcase
        end
    end

    // Squared threshold, registered from the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_sq_reg <= '0;
        end
        else
        begin
            lim_sq_reg <= LSQ_W'(max_dist_reg) * LSQ_W'(max_dist_reg);
        end
    end

    assign anchor_x = anchor_x_reg;
    assign anchor_y = anchor_y_reg;
    assign anchor_z = anchor_z_reg;
    assign dir_x    = dir_x_reg;
    assign dir_y    = dir_y_reg;
    assign dir_z    = dir_z_reg;
    assign lim_sq   = lim_sq_reg;

endmodule

@@ rtl/plf_proj.sv @@
// ============================================================================
// Point-line distance filter projection stages
// Stages 1-3: offset from anchor, direction products, projection t.
// ============================================================================
`timescale 1ns / 1ps

module plf_proj
    import plf_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    input  logic signed [COORD_BITS-1:0]        point_z,
    input  logic [INDEX_BITS-1:0]               point_index,
    input  logic signed [COORD_BITS-1:0]        anchor_x,
    input  logic signed [COORD_BITS-1:0]        anchor_y,
    input  logic signed [COORD_BITS-1:0]        anchor_z,
    input  logic signed [COORD_BITS-1:0]        dir_x,
    input  logic signed [COORD_BITS-1:0]        dir_y,
    input  logic signed [COORD_BITS-1:0]        dir_z,
    output logic                                out_valid,
    output logic signed [shr_width(2*COORD_BITS+3, DIR_FRAC_BITS)-1:0] proj_t,
    output logic signed [COORD_BITS:0]          diff_x,
    output logic signed [COORD_BITS:0]          diff_y,
    output logic signed [COORD_BITS:0]          diff_z,
    output logic [INDEX_BITS-1:0]               out_index
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = DIFF_W + COORD_BITS;
    localparam int DOT_W  = PROD_W + 2;
    localparam int T_W    = shr_width(DOT_W, DIR_FRAC_BITS);

    logic signed [COORD_BITS-1:0] pt  [AXES];
    logic signed [COORD_BITS-1:0] anc [AXES];
    logic signed [COORD_BITS-1:0] dir [AXES];

    logic signed [DIFF_W-1:0] diff_next [AXES];
    logic signed [PROD_W-1:0] prod_next [AXES];
    logic signed [DOT_W-1:0]  dot_next;
    logic signed [T_W-1:0]    t_next;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg [AXES];
    logic signed [DIFF_W-1:0] s2_diff_reg [AXES];
    logic signed [DIFF_W-1:0] s3_diff_reg [AXES];
    logic signed [PROD_W-1:0] s2_prod_reg [AXES];
    logic signed [T_W-1:0]    s3_t_reg;
    logic [INDEX_BITS-1:0]    s1_index_reg, s2_index_reg, s3_index_reg;

    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;
    assign anc[0] = anchor_x;
    assign anc[1] = anchor_y;
    assign anc[2] = anchor_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    // Per-axis offset and direction product
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            diff_next[i] = DIFF_W'(pt[i]) - DIFF_W'(anc[i]);
            prod_next[i] = PROD_W'(s1_diff_reg[i]) * PROD_W'(dir[i]);
        end
    end

    // Dot product and floor shift back to coordinate format
    always_comb
    begin
        dot_next = DOT_W'(s2_prod_reg[0]) + DOT_W'(s2_prod_reg[1]) + DOT_W'(s2_prod_reg[2]);
        t_next   = T_W'(dot_next >>> DIR_FRAC_BITS);
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXES; i++)
        begin
            s1_diff_reg[i] <= diff_next[i];
            s2_diff_reg[i] <= s1_diff_reg[i];
            s3_diff_reg[i] <= s2_diff_reg[i];
            s2_prod_reg[i] <= prod_next[i];
        end
        s1_index_reg <= point_index;
        s2_index_reg <= s1_index_reg;
        s3_index_reg <= s2_index_reg;
        s3_t_reg     <= t_next;
    end

    assign out_valid = s3_valid_reg;
    assign proj_t    = s3_t_reg;
    assign diff_x    = s3_diff_reg[0];
    assign diff_y    = s3_diff_reg[1];
    assign diff_z    = s3_diff_reg[2];
    assign out_index = s3_index_reg;

endmodule

@@ rtl/plf_resid.sv @@
// ============================================================================
// Point-line distance filter residual stages
// Stages 4-7: t*dir, residual, squares, summed length against threshold.
// ============================================================================
`timescale 1ns / 1ps

module plf_resid
    import plf_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [shr_width(2*COORD_BITS+3, DIR_FRAC_BITS)-1:0] proj_t,
    input  logic signed [COORD_BITS:0]          diff_x,
    input  logic signed [COORD_BITS:0]          diff_y,
    input  logic signed [COORD_BITS:0]          diff_z,
    input  logic [INDEX_BITS-1:0]               in_index,
    input  logic signed [COORD_BITS-1:0]        dir_x,
    input  logic signed [COORD_BITS-1:0]        dir_y,
    input  logic signed [COORD_BITS-1:0]        dir_z,
    input  logic [2*(COORD_BITS-1)-1:0]         lim_sq,
    output logic                                done,
    output logic [INDEX_BITS-1:0]               result_index,
    output logic                                is_close
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int T_W    = shr_width(2*COORD_BITS + 3, DIR_FRAC_BITS);
    localparam int TD_W   = T_W + COORD_BITS;
    localparam int TDS_W  = shr_width(TD_W, DIR_FRAC_BITS);
    localparam int R_W    = max_width(DIFF_W, TDS_W) + 1;
    localparam int SQ_W   = 2 * R_W;
    localparam int SUM_W  = SQ_W + 2;

    logic signed [COORD_BITS-1:0] dir   [AXES];
    logic signed [DIFF_W-1:0]     diff  [AXES];

    logic signed [TD_W-1:0]  td_next [AXES];
    logic signed [R_W-1:0]   r_next  [AXES];
    logic signed [SQ_W-1:0]  sq_next [AXES];
    logic [SUM_W-1:0]        sum_next;
    logic                    close_next;

    logic                    s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic signed [TD_W-1:0]  s4_td_reg   [AXES];
    logic signed [DIFF_W-1:0] s4_diff_reg [AXES];
    logic signed [R_W-1:0]   s5_r_reg    [AXES];
    logic signed [SQ_W-1:0]  s6_sq_reg   [AXES];
    logic [INDEX_BITS-1:0]   s4_index_reg, s5_index_reg, s6_index_reg, s7_index_reg;
    logic                    s7_close_reg;

    assign dir[0]  = dir_x;
    assign dir[1]  = dir_y;
    assign dir[2]  = dir_z;
    assign diff[0] = diff_x;
    assign diff[1] = diff_y;
    assign diff[2] = diff_z;

    // Per-axis t*dir, residual and square
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            td_next[i] = TD_W'(proj_t) * TD_W'(dir[i]);
            r_next[i]  = R_W'(s4_diff_reg[i])
                       - R_W'(TDS_W'(s4_td_reg[i] >>> DIR_FRAC_BITS));
            sq_next[i] = SQ_W'(s5_r_reg[i]) * SQ_W'(s5_r_reg[i]);
        end
    end

    // Squared length against squared threshold, inclusive
    always_comb
    begin
        sum_next   = SUM_W'($unsigned(s6_sq_reg[0]))
                   + SUM_W'($unsigned(s6_sq_reg[1]))
                   + SUM_W'($unsigned(s6_sq_reg[2]));
        close_next = (sum_next <= SUM_W'(lim_sq));
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < AXES; i++)
        begin
            s4_td_reg[i]   <= td_next[i];
            s4_diff_reg[i] <= diff[i];
            s5_r_reg[i]    <= r_next[i];
            s6_sq_reg[i]   <= sq_next[i];
        end
        s4_index_reg <= in_index;
        s5_index_reg <= s4_index_reg;
        s6_index_reg <= s5_index_reg;
        s7_index_reg <= s6_index_reg;
        s7_close_reg <= close_next;
    end

    assign done         = s7_valid_reg;
    assign result_index = s7_index_reg;
    assign is_close     = s7_close_reg;

endmodule

@@ rtl/point_line_distance_filter.sv @@
// ----------------------------------------------------------------------------
// Usage:
//   Point channel: drive point_x/y/z and point_index with start high; the
//   point is taken at any rising edge where start is high and busy is low.
//   busy stays low, so one point can be taken every cycle.
//   Result channel: done is high for one cycle with result_index and
//   is_close; the transaction completes at the edge ending that cycle.
//   Throughput is one point per cycle, set by the seven-stage pipeline
//   (three multiplier stages: d*dir, t*dir and r*r).
//   Config channel: cfg_valid/cfg_ready with cfg_addr and cfg_data; cfg_ready
//   is always high. Write only while no points are in flight.
//   Reset clears all stage valid bits and loads the anchor at the origin,
//   the direction along +x and a zero threshold; the receiver has no stall,
//   so results are never held back.
// ----------------------------------------------------------------------------
// ============================================================================
// Point-line distance filter top level
// Flags points whose squared distance to a configured 3D line is in range.
// ============================================================================
`timescale 1ns / 1ps

module point_line_distance_filter
    import plf_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  point_z,
    input  logic [INDEX_BITS-1:0]         point_index,
    output logic                          done,
    output logic [INDEX_BITS-1:0]         result_index,
    output logic                          is_close,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0]      cfg_addr,
    input  logic [COORD_BITS-1:0]         cfg_data
);

    localparam int T_W = shr_width(2*COORD_BITS + 3, DIR_FRAC_BITS);

    logic signed [COORD_BITS-1:0] anchor_x, anchor_y, anchor_z;
    logic signed [COORD_BITS-1:0] dir_x, dir_y, dir_z;
    logic [2*(COORD_BITS-1)-1:0]  lim_sq;

    logic                         mid_valid;
    logic signed [T_W-1:0]        mid_t;
    logic signed [COORD_BITS:0]   mid_diff_x, mid_diff_y, mid_diff_z;
    logic [INDEX_BITS-1:0]        mid_index;
    logic                         accept;

    // Pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    plf_cfg_regs #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_addr  (cfg_addr),
        .wr_data  (cfg_data),
        .anchor_x (anchor_x),
        .anchor_y (anchor_y),
        .anchor_z (anchor_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .lim_sq   (lim_sq)
    );

    // Stages 1-3
    plf_proj #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS),
        .INDEX_BITS    (INDEX_BITS)
    ) u_proj (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_index (point_index),
        .anchor_x    (anchor_x),
        .anchor_y    (anchor_y),
        .anchor_z    (anchor_z),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .out_valid   (mid_valid),
        .proj_t      (mid_t),
        .diff_x      (mid_diff_x),
        .diff_y      (mid_diff_y),
        .diff_z      (mid_diff_z),
        .out_index   (mid_index)
    );

    // Stages 4-7
    plf_resid #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS),
        .INDEX_BITS    (INDEX_BITS)
    ) u_resid (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid),
        .proj_t       (mid_t),
        .diff_x       (mid_diff_x),
        .diff_y       (mid_diff_y),
        .diff_z       (mid_diff_z),
        .in_index     (mid_index),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .lim_sq       (lim_sq),
        .done         (done),
        .result_index (result_index),
        .is_close     (is_close)
    );

endmodule

@@ rtl/plf_checker.sv @@
// ============================================================================
// Point-line distance filter checker
// Port-level timing and consistency assertions, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "point_line_distance_filter_macros.svh"

module plf_checker
    import plf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_BITS-1:0]  point_x,
    input logic signed [COORD_BITS-1:0]  point_y,
    input logic signed [COORD_BITS-1:0]  point_z,
    input logic [INDEX_BITS-1:0]         point_index,
    input logic                          done,
    input logic [INDEX_BITS-1:0]         result_index,
    input logic                          is_close,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [CFG_ADDR_BITS-1:0]      cfg_addr,
    input logic [COORD_BITS-1:0]         cfg_data
);

    localparam int QUIET_MAX = PIPE_LATENCY + 2;
    localparam int QUIET_W   = $clog2(QUIET_MAX + 1);

    logic [QUIET_W-1:0] quiet_cnt_reg;
    logic               cfg_quiet;

    // Cycles since the last config transaction, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cnt_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quiet_cnt_reg <= '0;
        end
        else if (quiet_cnt_reg != QUIET_W'(QUIET_MAX))
        begin
            quiet_cnt_reg <= quiet_cnt_reg + 1'b1;
        end
    end

    assign cfg_quiet = (quiet_cnt_reg == QUIET_W'(QUIET_MAX));

    // A result strobe always traces back to a point transaction
    `PLF_ASSERT_NEVER(a_no_spurious_result, clk, rst_n, done && !$past(start && !busy, PIPE_LATENCY), "result without matching point")

    // Index passes through with fixed latency
    `PLF_ASSERT_IMP(a_index_passthru, clk, rst_n, done, result_index == $past(point_index, PIPE_LATENCY), "result index mismatch")

    // Same point under same config gives the same verdict
    `PLF_ASSERT_IMP(a_same_point_same_flag, clk, rst_n, done && $past(done) && cfg_quiet && ($past(point_x, PIPE_LATENCY) == $past(point_x, PIPE_LATENCY + 1)) && ($past(point_y, PIPE_LATENCY) == $past(point_y, PIPE_LATENCY + 1)) && ($past(point_z, PIPE_LATENCY) == $past(point_z, PIPE_LATENCY + 1)), is_close == $past(is_close), "flag differs for repeated point")

    // Config fields are not checked here
    logic unused_cfg;
    assign unused_cfg = ^{cfg_addr, cfg_data};

endmodule

bind point_line_distance_filter plf_checker #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_plf_checker (.*);
